// ===== src/evsd_pkg.sv =====
// ----------------------------------------------------------------------------
// evsd_pkg
// shared constants, codes, command struct and word helpers for the dup/swap
// stack block
// ----------------------------------------------------------------------------
package evsd_pkg;

   localparam int STACK_LIMIT = 1024;
   localparam int WORD_BITS   = 64;
   localparam int MAX_POS     = 16;

   localparam int ADDR_BITS  = $clog2(STACK_LIMIT);
   localparam int DEPTH_BITS = $clog2(STACK_LIMIT + 1);

   localparam int FUNC_BITS      = 2;
   localparam int POS_BITS       = 5;
   localparam int EXT_WORD_BITS  = 64;
   localparam int GAS_BITS       = 63;
   localparam int PC_BITS        = 32;
   localparam int COST_BITS      = 8;
   localparam int STATUS_BITS    = 2;
   localparam int DEPTH_OUT_BITS = 11;

   localparam int REQ_FIELD_BITS = POS_BITS + EXT_WORD_BITS + 1 + GAS_BITS + PC_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = STATUS_BITS + GAS_BITS + PC_BITS + DEPTH_OUT_BITS
                                   + EXT_WORD_BITS + 1;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [0:0] REG_STEP_COST = 1'b0;
   localparam logic [COST_BITS-1:0] STEP_COST_RESET = 8'd3;

   typedef enum logic [1:0] {
      FN_PUSH = 2'd0,
      FN_DUP  = 2'd1,
      FN_SWAP = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      STS_OK         = 2'd0,
      STS_OUT_OF_GAS = 2'd1,
      STS_UNDERFLOW  = 2'd2,
      STS_OVERFLOW   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_PUSH = 2'd1,
      ACT_DUP  = 2'd2,
      ACT_SWAP = 2'd3
   } action_type;

   typedef struct packed {
      logic load;
      logic decode;
      logic commit;
   } dp_cmd_type;

   typedef logic [WORD_BITS-1:0] word_type;

   function automatic word_type to_word(input logic [EXT_WORD_BITS-1:0] v);
      word_type r;
      r = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (i < EXT_WORD_BITS) begin
            r[i] = v[i];
         end
      end
      return r;
   endfunction

   function automatic logic [EXT_WORD_BITS-1:0] from_word(input word_type w);
      logic [EXT_WORD_BITS-1:0] r;
      r = '0;
      for (int i = 0; i < EXT_WORD_BITS; i++) begin
         if (i < WORD_BITS) begin
            r[i] = w[i];
         end
      end
      return r;
   endfunction

   function automatic logic [DEPTH_OUT_BITS-1:0] to_depth_out(
      input logic [DEPTH_BITS-1:0] d);
      logic [DEPTH_OUT_BITS-1:0] r;
      r = '0;
      for (int i = 0; i < DEPTH_OUT_BITS; i++) begin
         if (i < DEPTH_BITS) begin
            r[i] = d[i];
         end
      end
      return r;
   endfunction

endpackage

// ===== src/evsd_csr.sv =====
// ----------------------------------------------------------------------------
// evsd_csr
// register port holding the gas charge per dup or swap
// ----------------------------------------------------------------------------
module evsd_csr
   import evsd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output logic [COST_BITS-1:0]     step_cost
);

   logic [COST_BITS-1:0] step_cost_ff;
   logic [COST_BITS-1:0] step_cost_in;
   logic                 hit_cost;

   // word address: low two bits select a byte and are ignored
   assign hit_cost   = (csr_paddr[CSR_ADDR_BITS-1:2] == REG_STEP_COST);
   assign csr_pready = 1'b1;

   always_comb begin
      step_cost_in = step_cost_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && hit_cost) begin
         step_cost_in = csr_pwdata[COST_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_cost_ff <= STEP_COST_RESET;
      end else begin
         step_cost_ff <= step_cost_in;
      end
   end

   assign csr_prdata = hit_cost ? CSR_DATA_BITS'(step_cost_ff) : '0;
   assign step_cost  = step_cost_ff;

endmodule

// ===== src/evsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// evsd_ctrl
// sequencer: accept, decode with memory read, commit into result register
// ----------------------------------------------------------------------------
module evsd_ctrl
   import evsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_READ  = 3'b010,
      S_WRITE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      commit;

   // commit once the result register is free or being emptied
   assign commit     = (state_ff == S_WRITE) && (!out_valid_ff || rsp_tready);
   assign req_tready = (state_ff == S_IDLE) || commit;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            if (commit) begin
               state_in = req_tvalid ? S_READ : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (commit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign cmd.load   = req_tvalid && req_tready;
   assign cmd.decode = (state_ff == S_READ);
   assign cmd.commit = commit;

endmodule

// ===== src/evsd_datapath.sv =====
// ----------------------------------------------------------------------------
// evsd_datapath
// item registers, gas and depth checks, stack memory with the top word
// cached in registers, and the result register
// ----------------------------------------------------------------------------
module evsd_datapath
   import evsd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  dp_cmd_type                cmd,
   input  logic [FUNC_BITS-1:0]      func,
   input  logic [POS_BITS-1:0]       position,
   input  logic [EXT_WORD_BITS-1:0]  push_value,
   input  logic                      push_flag,
   input  logic [GAS_BITS-1:0]       gas_in,
   input  logic [PC_BITS-1:0]        pc_in,
   input  logic [COST_BITS-1:0]      step_cost,
   output logic [STATUS_BITS-1:0]    status,
   output logic [GAS_BITS-1:0]       gas_out,
   output logic [PC_BITS-1:0]        pc_out,
   output logic [DEPTH_OUT_BITS-1:0] depth_out,
   output logic [EXT_WORD_BITS-1:0]  top_word,
   output logic                      top_flag
);

   // stack entry: flag above the word; slots below depth-1 live in memory,
   // the top slot lives only in the cache registers
   logic [WORD_BITS:0] stack_mem [STACK_LIMIT];
   logic [WORD_BITS:0] rd_entry_ff;

   logic [FUNC_BITS-1:0]     func_ff;
   logic [POS_BITS-1:0]      pos_ff;
   logic [EXT_WORD_BITS-1:0] value_ff;
   logic                     flag_ff;
   logic [GAS_BITS-1:0]      gas_ff;
   logic [PC_BITS-1:0]       pc_ff;

   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic [WORD_BITS:0]    top_ff, top_in;

   action_type            dec_act_ff, dec_act_in;
   status_type            dec_status_ff, dec_status_in;
   logic [GAS_BITS-1:0]   dec_gas_ff, dec_gas_in;
   logic [PC_BITS-1:0]    dec_pc_ff, dec_pc_in;
   logic                  dec_from_top_ff, dec_from_top_in;
   logic [ADDR_BITS-1:0]  dec_addr_ff, dec_addr_in;

   logic [DEPTH_BITS-1:0] n_ext;
   logic [DEPTH_BITS-1:0] rd_ptr;
   logic                  pos_ok;
   logic                  gas_short;
   logic                  full;
   logic [GAS_BITS-1:0]   gas_after;

   logic                  wr_en;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [DEPTH_BITS-1:0] top_ptr;

   logic [STATUS_BITS-1:0]    out_status_ff;
   logic [GAS_BITS-1:0]       out_gas_ff;
   logic [PC_BITS-1:0]        out_pc_ff;
   logic [DEPTH_OUT_BITS-1:0] out_depth_ff;
   logic [EXT_WORD_BITS-1:0]  out_word_ff;
   logic                      out_flag_ff;

   // item registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= func;
         pos_ff   <= position;
         value_ff <= push_value;
         flag_ff  <= push_flag;
         gas_ff   <= gas_in;
         pc_ff    <= pc_in;
      end
   end

   // decode
   assign n_ext     = DEPTH_BITS'(pos_ff);
   assign pos_ok    = pos_ff inside {[1:MAX_POS]};
   assign gas_short = gas_ff < GAS_BITS'(step_cost);
   assign gas_after = gas_ff - GAS_BITS'(step_cost);
   assign full      = depth_ff >= DEPTH_BITS'(STACK_LIMIT);
   // dup reads depth-n, swap reads depth-1-n
   assign rd_ptr    = depth_ff - n_ext - ((func_ff == FN_SWAP) ? DEPTH_BITS'(1) : '0);

   always_comb begin
      dec_act_in      = ACT_NONE;
      dec_status_in   = STS_OK;
      dec_gas_in      = gas_ff;
      dec_pc_in       = pc_ff;
      dec_from_top_in = (pos_ff == POS_BITS'(1));
      dec_addr_in     = rd_ptr[ADDR_BITS-1:0];
      case (func_ff)
         FN_PUSH: begin
            if (full) begin
               dec_status_in = STS_OVERFLOW;
            end else begin
               dec_act_in = ACT_PUSH;
            end
         end
         FN_DUP, FN_SWAP: begin
            if (pos_ok) begin
               if (gas_short) begin
                  dec_status_in = STS_OUT_OF_GAS;
               end else begin
                  dec_gas_in = gas_after;
                  if (func_ff == FN_DUP) begin
                     if (depth_ff < n_ext) begin
                        dec_status_in = STS_UNDERFLOW;
                     end else if (full) begin
                        dec_status_in = STS_OVERFLOW;
                     end else begin
                        dec_act_in = ACT_DUP;
                        dec_pc_in  = pc_ff + PC_BITS'(1);
                     end
                  end else begin
                     if (depth_ff <= n_ext) begin
                        dec_status_in = STS_UNDERFLOW;
                     end else begin
                        dec_act_in = ACT_SWAP;
                        dec_pc_in  = pc_ff + PC_BITS'(1);
                     end
                  end
               end
            end
         end
         default: begin
            dec_act_in = ACT_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         dec_act_ff      <= dec_act_in;
         dec_status_ff   <= dec_status_in;
         dec_gas_ff      <= dec_gas_in;
         dec_pc_ff       <= dec_pc_in;
         dec_from_top_ff <= dec_from_top_in;
         dec_addr_ff     <= dec_addr_in;
      end
   end

   // commit: push and dup spill the cached top into memory, swap writes the
   // cached top into the other slot
   assign top_ptr = depth_ff - DEPTH_BITS'(1);

   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = dec_addr_ff;
      top_in   = top_ff;
      depth_in = depth_ff;
      case (dec_act_ff)
         ACT_PUSH: begin
            wr_en    = (depth_ff != '0);
            wr_addr  = top_ptr[ADDR_BITS-1:0];
            top_in   = {flag_ff, to_word(value_ff)};
            depth_in = depth_ff + DEPTH_BITS'(1);
         end
         ACT_DUP: begin
            wr_en    = (depth_ff != '0);
            wr_addr  = top_ptr[ADDR_BITS-1:0];
            top_in   = dec_from_top_ff ? top_ff : rd_entry_ff;
            depth_in = depth_ff + DEPTH_BITS'(1);
         end
         ACT_SWAP: begin
            wr_en  = 1'b1;
            top_in = rd_entry_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         stack_mem[wr_addr] <= top_ff;
      end
      if (cmd.decode) begin
         rd_entry_ff <= stack_mem[rd_ptr[ADDR_BITS-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else if (cmd.commit) begin
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         top_ff        <= top_in;
         out_status_ff <= dec_status_ff;
         out_gas_ff    <= dec_gas_ff;
         out_pc_ff     <= dec_pc_ff;
         out_depth_ff  <= to_depth_out(depth_in);
         out_word_ff   <= (depth_in == '0) ? '0 : from_word(top_in[WORD_BITS-1:0]);
         out_flag_ff   <= (depth_in != '0) && top_in[WORD_BITS];
      end
   end

   assign status    = out_status_ff;
   assign gas_out   = out_gas_ff;
   assign pc_out    = out_pc_ff;
   assign depth_out = out_depth_ff;
   assign top_word  = out_word_ff;
   assign top_flag  = out_flag_ff;

endmodule

// ===== src/evm_stack_dup_swap.sv =====
// ----------------------------------------------------------------------------
// evm_stack_dup_swap
// word stack with per-word flag running push, DUPn and SWAPn with gas charge
//
// channel   direction  payload
// req_*     in         tuser: func; tdata: position, push_value, push_flag,
//                      gas_in, pc_in
// rsp_*     out        tdata: status, gas_out, pc_out, depth_out, top_word,
//                      top_flag
// csr_*     in/out     step_cost at byte address 0
//
// each item is decoded with a stack memory read, then committed with at most one
// memory write; the registered memory read ahead of the commit keeps them apart
// the top word sits in registers, so a swap needs one read and one write
// reset clears depth and the control state; memory is not cleared
// a stalled result register holds the commit until it drains; the next item
// is taken in the commit cycle
// ----------------------------------------------------------------------------
module evm_stack_dup_swap
   import evsd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // req_tdata: position[4:0], push_value[68:5], push_flag[69], gas_in[132:70],
   // pc_in[164:133]
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // req_tuser: func[1:0]
   input  logic [FUNC_BITS-1:0]     req_tuser,
   // rsp_tdata: status[1:0], gas_out[64:2], pc_out[96:65], depth_out[107:97],
   // top_word[171:108], top_flag[172]
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   dp_cmd_type                cmd;
   logic [COST_BITS-1:0]      step_cost;
   logic [STATUS_BITS-1:0]    rsp_status;
   logic [GAS_BITS-1:0]       rsp_gas;
   logic [PC_BITS-1:0]        rsp_pc;
   logic [DEPTH_OUT_BITS-1:0] rsp_depth;
   logic [EXT_WORD_BITS-1:0]  rsp_word;
   logic                      rsp_flag;

   evsd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .step_cost   (step_cost)
   );

   evsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   evsd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .func       (req_tuser),
      .position   (req_tdata[4:0]),
      .push_value (req_tdata[68:5]),
      .push_flag  (req_tdata[69]),
      .gas_in     (req_tdata[132:70]),
      .pc_in      (req_tdata[164:133]),
      .step_cost  (step_cost),
      .status     (rsp_status),
      .gas_out    (rsp_gas),
      .pc_out     (rsp_pc),
      .depth_out  (rsp_depth),
      .top_word   (rsp_word),
      .top_flag   (rsp_flag)
   );

   assign rsp_tdata = RSP_DATA_BITS'({rsp_flag, rsp_word, rsp_depth, rsp_pc,
                                      rsp_gas, rsp_status});

   // an item spends its decode cycle with the input closed
   a_decode_closed: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input open during decode");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_depth <= DEPTH_OUT_BITS'(STACK_LIMIT)))
      else $error("depth beyond stack limit");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_depth == '0)) |-> (rsp_word == '0 && !rsp_flag))
      else $error("empty stack shows a top word");

   // results only appear after a commit, which needs an accepted item
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.commit))
      else $error("result without commit");

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the dup/swap word stack: drives push, DUPn, SWAPn
// and unused codes over the request stream, tracks stack, gas and pc in a
// scoreboard of its own and compares every result field by field, with
// bursty request traffic, result backpressure and step cost changes
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import evsd_pkg::*;

   localparam logic [1:0] FN_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_BITS-1:0] STEP_COST_ADDR = {REG_STEP_COST, 2'b00};

   // packed from the top down, so status lands in the low bits
   typedef struct packed {
      logic                      top_flag;
      logic [EXT_WORD_BITS-1:0]  top_word;
      logic [DEPTH_OUT_BITS-1:0] depth;
      logic [PC_BITS-1:0]        pc;
      logic [GAS_BITS-1:0]       gas;
      status_type                status;
   } stack_result_type;

   class stack_scoreboard_type;
      logic [EXT_WORD_BITS-1:0] words [STACK_LIMIT];
      bit                       flags [STACK_LIMIT];
      int unsigned              depth;
      logic [COST_BITS-1:0]     cost;
      stack_result_type         pending_results [$];
      int unsigned              accepted;
      int unsigned              checked;
      int unsigned              mismatches;

      function new();
         depth = 0;
         cost = STEP_COST_RESET;
         accepted = 0;
         checked = 0;
         mismatches = 0;
      endfunction

      function int unsigned pending();
         return pending_results.size();
      endfunction

      function void report(string msg);
         if (mismatches < 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
         end
         mismatches++;
      endfunction

      function void note_request(logic [1:0] fn, logic [POS_BITS-1:0] pos,
                                 logic [EXT_WORD_BITS-1:0] val, logic flg,
                                 logic [GAS_BITS-1:0] gas, logic [PC_BITS-1:0] pc);
         stack_result_type r;
         int unsigned n;
         int unsigned top;
         int unsigned other;
         logic [EXT_WORD_BITS-1:0] w;
         bit f;
         r = '0;
         r.status = STS_OK;
         r.gas = gas;
         r.pc = pc;
         n = pos;
         accepted++;
         if (fn == FN_PUSH) begin
            if (depth >= STACK_LIMIT) begin
               r.status = STS_OVERFLOW;
            end else begin
               words[depth] = val;
               flags[depth] = flg;
               depth++;
            end
         end else if ((fn == FN_DUP || fn == FN_SWAP) && n >= 1 && n <= MAX_POS) begin
            if (gas < GAS_BITS'(cost)) begin
               r.status = STS_OUT_OF_GAS;
            end else begin
               // charge sticks even when the depth check fails
               r.gas = gas - GAS_BITS'(cost);
               if (fn == FN_DUP) begin
                  if (depth < n) begin
                     r.status = STS_UNDERFLOW;
                  end else if (depth >= STACK_LIMIT) begin
                     r.status = STS_OVERFLOW;
                  end else begin
                     words[depth] = words[depth - n];
                     flags[depth] = flags[depth - n];
                     depth++;
                     r.pc = pc + 1'b1;
                  end
               end else begin
                  if (depth < n + 1) begin
                     r.status = STS_UNDERFLOW;
                  end else begin
                     top = depth - 1;
                     other = depth - 1 - n;
                     w = words[top];
                     f = flags[top];
                     words[top] = words[other];
                     flags[top] = flags[other];
                     words[other] = w;
                     flags[other] = f;
                     r.pc = pc + 1'b1;
                  end
               end
            end
         end
         r.depth = DEPTH_OUT_BITS'(depth);
         if (depth > 0) begin
            r.top_word = words[depth - 1];
            r.top_flag = flags[depth - 1];
         end
         pending_results.push_back(r);
      endfunction

      function void check_result(stack_result_type act);
         stack_result_type exp;
         if (pending_results.size() == 0) begin
            report($sformatf("result with nothing expected: %h", act));
            return;
         end
         exp = pending_results.pop_front();
         checked++;
         if (act.status !== exp.status)
            report($sformatf("status exp %0d act %0d", exp.status, act.status));
         if (act.gas !== exp.gas)
            report($sformatf("gas_out exp %h act %h", exp.gas, act.gas));
         if (act.pc !== exp.pc)
            report($sformatf("pc_out exp %h act %h", exp.pc, act.pc));
         if (act.depth !== exp.depth)
            report($sformatf("depth_out exp %0d act %0d", exp.depth, act.depth));
         if (act.top_word !== exp.top_word)
            report($sformatf("top_word exp %h act %h", exp.top_word, act.top_word));
         if (act.top_flag !== exp.top_flag)
            report($sformatf("top_flag exp %b act %b", exp.top_flag, act.top_flag));
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic [FUNC_BITS-1:0]     req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   stack_scoreboard_type sb;
   int burst_left;
   int stall_mode;
   int stall_left;
   int cost_settings;

   evm_stack_dup_swap uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result backpressure: modes switch every so often, including no stalls
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 200);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 1) == 1);
         2: rsp_tready <= (stall_left % 3 != 0);
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         sb.check_result(rsp_tdata[RSP_FIELD_BITS-1:0]);
      end
   end

   task automatic send_item(input logic [1:0] fn, input logic [POS_BITS-1:0] pos,
                            input logic [EXT_WORD_BITS-1:0] val, input logic flg,
                            input logic [GAS_BITS-1:0] gas, input logic [PC_BITS-1:0] pc);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= fn;
      req_tdata <= REQ_DATA_BITS'({pc, gas, flg, val, pos});
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_request(fn, pos, val, flg, gas, pc);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_cost(input logic [COST_BITS-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= STEP_COST_ADDR;
      csr_pwdata <= CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      // read back through the same port
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata !== CSR_DATA_BITS'(value))
         sb.report($sformatf("step_cost read exp %h act %h", value, csr_prdata));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      sb.cost = value;
      cost_settings++;
   endtask

   task automatic random_item();
      logic [1:0]               fn;
      logic [POS_BITS-1:0]      pos;
      logic [EXT_WORD_BITS-1:0] val;
      logic [63:0]              g64;
      logic [GAS_BITS-1:0]      gas;
      logic [PC_BITS-1:0]       pc;
      int                       pick;
      pick = $urandom_range(0, 99);
      if (pick < 38) fn = FN_PUSH;
      else if (pick < 70) fn = FN_DUP;
      else if (pick < 96) fn = FN_SWAP;
      else fn = FN_UNUSED;
      if ($urandom_range(0, 9) == 0) pos = POS_BITS'($urandom_range(0, 31));
      else pos = POS_BITS'($urandom_range(1, MAX_POS));
      val = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: val = '0;
         1: val = '1;
         default: ;
      endcase
      g64 = {$urandom, $urandom};
      gas = g64[GAS_BITS-1:0];
      case ($urandom_range(0, 7))
         0, 1: gas = GAS_BITS'($urandom_range(0, int'(sb.cost) + 3));
         2: gas = '1;
         3: gas = GAS_BITS'($urandom_range(0, 1000));
         default: ;
      endcase
      pc = $urandom;
      if ($urandom_range(0, 9) == 0) pc = '1;
      send_item(fn, pos, val, 1'($urandom_range(0, 1)), gas, pc);
   endtask

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      logic [GAS_BITS-1:0] gas_max;
      logic [7:0] costs [5];
      sb = new();
      gas_max = '1;
      burst_left = 0;
      stall_mode = 0;
      stall_left = 0;
      cost_settings = 0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      rsp_tready <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: edge cases starting from an empty stack at the reset step cost
      send_item(FN_DUP, 5'd1, '0, 1'b0, 63'd10, 32'd0);
      send_item(FN_SWAP, 5'd1, '0, 1'b0, 63'd10, 32'd5);
      send_item(FN_DUP, 5'd1, '0, 1'b0, 63'd2, 32'd7);
      send_item(FN_SWAP, 5'd16, '0, 1'b0, 63'd0, 32'd7);
      send_item(FN_PUSH, 5'd0, '1, 1'b1, gas_max, '1);
      send_item(FN_DUP, 5'd1, '0, 1'b0, 63'd3, '1);
      send_item(FN_PUSH, 5'd31, 64'h5555_aaaa_0f0f_f0f0, 1'b0, 63'd9, 32'd1);
      send_item(FN_SWAP, 5'd1, '0, 1'b0, gas_max, 32'd100);
      send_item(FN_SWAP, 5'd3, '0, 1'b0, gas_max, 32'd101);
      send_item(FN_DUP, 5'd4, '0, 1'b0, 63'd50, 32'd102);
      send_item(FN_DUP, 5'd16, '0, 1'b0, 63'd50, 32'd102);
      send_item(FN_PUSH, 5'd16, '0, 1'b0, '0, '0);
      send_item(FN_DUP, 5'd0, '0, 1'b0, 63'd50, 32'd200);
      send_item(FN_SWAP, 5'd17, '0, 1'b0, 63'd50, 32'd201);
      send_item(FN_DUP, 5'd31, '0, 1'b0, 63'd50, 32'd202);
      send_item(FN_UNUSED, 5'd2, '1, 1'b1, gas_max, '1);
      send_item(FN_DUP, 5'd4, '0, 1'b0, 63'd3, 32'd300);
      send_item(FN_SWAP, 5'd4, '0, 1'b0, 63'd4, 32'd301);
      send_item(FN_SWAP, 5'd2, '0, 1'b0, gas_max, 32'd302);
      drain();

      costs[0] = 8'd0;
      costs[1] = 8'd255;
      costs[2] = 8'($urandom_range(1, 254));
      costs[3] = 8'd1;
      costs[4] = 8'd3;
      foreach (costs[i]) begin
         write_cost(costs[i]);
         repeat (24) random_item();
         drain();
      end

      // grow the stack to its limit, then work against a full stack
      write_cost(8'($urandom_range(0, 255)));
      while (sb.depth < STACK_LIMIT) begin
         if ($urandom_range(0, 1) == 0)
            send_item(FN_PUSH, POS_BITS'($urandom_range(0, 31)), {$urandom, $urandom},
                      1'($urandom_range(0, 1)), GAS_BITS'($urandom), $urandom);
         else
            send_item(FN_DUP, POS_BITS'($urandom_range(1, MAX_POS)), '0, 1'b0,
                      gas_max, $urandom);
      end
      repeat (20) random_item();
      drain();
      repeat (20) @(posedge clock);

      $display("run covered %0d items and checked %0d results over %0d step cost settings",
               sb.accepted, sb.checked, cost_settings);
      $display("stack reached depth %0d of %0d; %0d mismatches",
               sb.depth, STACK_LIMIT, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/evsd_pkg.sv
src/evsd_csr.sv
src/evsd_ctrl.sv
src/evsd_datapath.sv
src/evm_stack_dup_swap.sv
verif/tb_top.sv
